>>> rtl/assert_macros.svh
// assertion macros shared by the histogram median threshold rtl
// no dependencies; included by the modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/hmt_pkg.sv
// shared constants and types for the histogram median threshold block
// no dependencies; used by every module under rtl except hmt_ram
package hmt_pkg;

   localparam int MAX_PIXELS  = 1048576;
   localparam int GRAY_LEVELS = 256;

   localparam int LEVEL_W   = 8;
   localparam int BIN_DEPTH = 256;
   localparam int CNT_W     = $clog2(MAX_PIXELS + 1);
   localparam int PCT_W     = 8;
   localparam int PROD_W    = LEVEL_W + PCT_W;

   localparam logic [LEVEL_W-1:0] LEVEL_TOP = LEVEL_W'(GRAY_LEVELS - 1);
   localparam logic [CNT_W-1:0]   CNT_MAX   = CNT_W'(MAX_PIXELS);
   localparam logic [LEVEL_W-1:0] LEVEL_CAP = LEVEL_W'(255);

   // floor(x/100) = (x * RECIP) >> RECIP_SHIFT, exact for any 16-bit x
   localparam int                 RECIP_W     = 17;
   localparam int                 RECIP_SHIFT = 23;
   localparam logic [RECIP_W-1:0] RECIP       = RECIP_W'(83887);
   localparam int                 QFULL_W     = PROD_W + RECIP_W;

   localparam logic [PCT_W-1:0] UPPER_PCT_RESET = PCT_W'(115);
   localparam logic [PCT_W-1:0] LOWER_PCT_RESET = PCT_W'(66);

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = PCT_W;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER_PCT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWER_PCT = 1'b1;

   typedef struct packed {
      logic accept;
      logic walk_init;
      logic walk_en;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic found;
      logic slot_free;
   } status_type;

endpackage

>>> rtl/hmt_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module hmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/hmt_ctrl.sv
// controller fsm: pixel intake, flush, histogram walk
// depends on hmt_pkg and assert_macros.svh
`include "assert_macros.svh"

module hmt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_last_pixel,
   output logic                req_ready,
   input  hmt_pkg::status_type status_in,
   output hmt_pkg::cmd_type    cmd_out
);

   typedef enum logic [2:0] {
      ST_ACCUM = 3'b001,
      ST_FLUSH = 3'b010,
      ST_WALK  = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   always_comb begin
      state_in = state_ff;
      cmd_out  = '0;
      // a last pixel waits until the previous result has left
      req_ready = (state_ff == ST_ACCUM) && (!req_last_pixel || status_in.slot_free);
      accept    = req_valid && req_ready;
      cmd_out.accept = accept;
      unique case (state_ff)
         ST_ACCUM: begin
            if (accept && req_last_pixel) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            // last pixel write-back lands this cycle
            cmd_out.walk_init = 1'b1;
            state_in          = ST_WALK;
         end
         ST_WALK: begin
            cmd_out.walk_en = 1'b1;
            if (status_in.found) begin
               cmd_out.clear = 1'b1;
               state_in      = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCUM;
      end else begin
         state_ff <= state_in;
      end
   end

   `ASSERT_NEXT(a_last_goes_flush, clock, reset, accept && req_last_pixel, state_ff == ST_FLUSH, "last pixel did not start flush")
   `ASSERT_ALWAYS(a_no_accept_in_walk, clock, reset, cmd_out.walk_en |-> !cmd_out.accept, "pixel accepted during walk")

endmodule

>>> rtl/hmt_datapath.sv
// datapath: histogram ram with read-modify-write, median walk, threshold
// scaling and result register; depends on hmt_pkg, hmt_ram, assert_macros.svh
`include "assert_macros.svh"

module hmt_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  hmt_pkg::cmd_type                   cmd_in,
   output hmt_pkg::status_type                status_out,
   input  logic [hmt_pkg::LEVEL_W-1:0]        req_gray_pixel,
   input  logic                               csr_write_enable,
   input  logic [hmt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [hmt_pkg::CSR_DATA_W-1:0]     csr_write_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [hmt_pkg::LEVEL_W-1:0]        rsp_median_level,
   output logic [hmt_pkg::LEVEL_W-1:0]        rsp_upper_level,
   output logic [hmt_pkg::LEVEL_W-1:0]        rsp_lower_level,
   output logic                               rsp_count_overflow
);

   localparam int LW = hmt_pkg::LEVEL_W;
   localparam int CW = hmt_pkg::CNT_W;

   // configuration
   logic [hmt_pkg::PCT_W-1:0] upper_pct_ff, lower_pct_ff;

   // intake and histogram state
   logic [CW-1:0]                   total_ff, total_in;
   logic                            ovf_ff, ovf_in;
   logic [hmt_pkg::BIN_DEPTH-1:0]   bin_vld_ff, bin_vld_in;
   logic                            s1_valid_ff, s1_valid_in;
   logic [LW-1:0]                   s1_addr_ff, s1_addr_in;
   logic                            fwd_valid_ff, fwd_valid_in;
   logic [LW-1:0]                   fwd_addr_ff;
   logic [CW-1:0]                   fwd_data_ff;
   logic                            rd_vbit_ff;
   logic [LW-1:0]                   level_clamp;
   logic [LW-1:0]                   rd_addr;
   logic [CW-1:0]                   ram_rdata;
   logic [CW-1:0]                   bin_count;
   logic [CW-1:0]                   bin_old;
   logic [CW-1:0]                   bin_new;

   // walk
   logic [LW-1:0] walk_addr_ff, walk_addr_in;
   logic          walk_issue_ff, walk_issue_in;
   logic          rd_pending_ff, rd_pending_in;
   logic [LW-1:0] rd_bin_ff, rd_bin_in;
   logic [CW-1:0] run_ff, run_in;
   logic [CW-1:0] run_sum;
   logic          found;

   // scaling and result
   logic                          sc_valid_ff;
   logic [LW-1:0]                 sc_median_ff;
   logic                          sc_ovf_ff;
   logic [hmt_pkg::PROD_W-1:0]    sc_prod_up_ff, sc_prod_lo_ff;
   logic [hmt_pkg::QFULL_W-1:0]   q_up_full, q_lo_full;
   logic [hmt_pkg::QFULL_W-hmt_pkg::RECIP_SHIFT-1:0] q_up, q_lo;
   logic [LW-1:0]                 up_cap, lo_cap;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [LW-1:0]                 rsp_median_ff, rsp_upper_ff, rsp_lower_ff;
   logic                          rsp_ovf_ff;

   hmt_ram #(
      .WIDTH (hmt_pkg::CNT_W),
      .DEPTH (hmt_pkg::BIN_DEPTH)
   ) u_bins (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (bin_new),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      level_clamp = (req_gray_pixel > hmt_pkg::LEVEL_TOP) ? hmt_pkg::LEVEL_TOP
                                                          : req_gray_pixel;
      rd_addr   = cmd_in.walk_en ? walk_addr_ff : level_clamp;
      bin_count = rd_vbit_ff ? ram_rdata : '0;

      // read-modify-write, forwarding the most recent bin write
      bin_old = (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) ? fwd_data_ff : bin_count;
      bin_new = bin_old + CW'(1);

      total_in    = total_ff;
      ovf_in      = ovf_ff;
      s1_valid_in = 1'b0;
      s1_addr_in  = level_clamp;
      if (cmd_in.accept) begin
         if (total_ff >= hmt_pkg::CNT_MAX) begin
            ovf_in = 1'b1;
         end else begin
            total_in    = total_ff + CW'(1);
            s1_valid_in = 1'b1;
         end
      end

      bin_vld_in   = bin_vld_ff;
      fwd_valid_in = fwd_valid_ff;
      if (s1_valid_ff) begin
         bin_vld_in[s1_addr_ff] = 1'b1;
         fwd_valid_in           = 1'b1;
      end

      // walk: one address issued per cycle, its data returns in the next cycle
      walk_addr_in  = walk_addr_ff;
      walk_issue_in = walk_issue_ff;
      rd_pending_in = 1'b0;
      rd_bin_in     = rd_bin_ff;
      run_in        = run_ff;
      run_sum       = run_ff + bin_count;
      found         = cmd_in.walk_en && rd_pending_ff && (run_sum >= (total_ff >> 1));
      if (cmd_in.walk_init) begin
         walk_addr_in  = '0;
         walk_issue_in = 1'b1;
         run_in        = '0;
      end else if (cmd_in.walk_en) begin
         if (walk_issue_ff) begin
            rd_pending_in = 1'b1;
            rd_bin_in     = walk_addr_ff;
            if (walk_addr_ff == hmt_pkg::LEVEL_TOP) begin
               walk_issue_in = 1'b0;
            end else begin
               walk_addr_in = walk_addr_ff + LW'(1);
            end
         end
         if (rd_pending_ff) begin
            run_in = run_sum;
         end
      end

      if (cmd_in.clear) begin
         total_in     = '0;
         ovf_in       = 1'b0;
         bin_vld_in   = '0;
         fwd_valid_in = 1'b0;
         walk_issue_in = 1'b0;
      end

      // divide by 100 through the reciprocal, then cap
      q_up_full = hmt_pkg::QFULL_W'(sc_prod_up_ff) * hmt_pkg::QFULL_W'(hmt_pkg::RECIP);
      q_lo_full = hmt_pkg::QFULL_W'(sc_prod_lo_ff) * hmt_pkg::QFULL_W'(hmt_pkg::RECIP);
      q_up      = q_up_full[hmt_pkg::QFULL_W-1:hmt_pkg::RECIP_SHIFT];
      q_lo      = q_lo_full[hmt_pkg::QFULL_W-1:hmt_pkg::RECIP_SHIFT];
      up_cap    = (q_up > hmt_pkg::LEVEL_CAP) ? hmt_pkg::LEVEL_CAP : q_up[LW-1:0];
      lo_cap    = (q_lo > hmt_pkg::LEVEL_CAP) ? hmt_pkg::LEVEL_CAP : q_lo[LW-1:0];

      rsp_valid_in = rsp_valid_ff;
      if (sc_valid_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_pct_ff  <= hmt_pkg::UPPER_PCT_RESET;
         lower_pct_ff  <= hmt_pkg::LOWER_PCT_RESET;
         total_ff      <= '0;
         ovf_ff        <= 1'b0;
         bin_vld_ff    <= '0;
         s1_valid_ff   <= 1'b0;
         fwd_valid_ff  <= 1'b0;
         walk_issue_ff <= 1'b0;
         rd_pending_ff <= 1'b0;
         sc_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               hmt_pkg::CSR_UPPER_PCT: upper_pct_ff <= csr_write_data;
               hmt_pkg::CSR_LOWER_PCT: lower_pct_ff <= csr_write_data;
               default: begin
               end
            endcase
         end
         total_ff      <= total_in;
         ovf_ff        <= ovf_in;
         bin_vld_ff    <= bin_vld_in;
         s1_valid_ff   <= s1_valid_in;
         fwd_valid_ff  <= fwd_valid_in;
         walk_issue_ff <= walk_issue_in;
         rd_pending_ff <= rd_pending_in;
         sc_valid_ff   <= found;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_addr_ff   <= s1_addr_in;
      rd_vbit_ff   <= bin_vld_ff[rd_addr];
      walk_addr_ff <= walk_addr_in;
      rd_bin_ff    <= rd_bin_in;
      run_ff       <= run_in;
      if (s1_valid_ff) begin
         fwd_addr_ff <= s1_addr_ff;
         fwd_data_ff <= bin_new;
      end
      if (found) begin
         sc_median_ff  <= rd_bin_ff;
         sc_ovf_ff     <= ovf_ff;
         sc_prod_up_ff <= hmt_pkg::PROD_W'(rd_bin_ff) * hmt_pkg::PROD_W'(upper_pct_ff);
         sc_prod_lo_ff <= hmt_pkg::PROD_W'(rd_bin_ff) * hmt_pkg::PROD_W'(lower_pct_ff);
      end
      if (sc_valid_ff) begin
         rsp_median_ff <= sc_median_ff;
         rsp_upper_ff  <= up_cap;
         rsp_lower_ff  <= lo_cap;
         rsp_ovf_ff    <= sc_ovf_ff;
      end
   end

   assign status_out.found     = found;
   assign status_out.slot_free = !rsp_valid_ff && !sc_valid_ff;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_median_level   = rsp_median_ff;
   assign rsp_upper_level    = rsp_upper_ff;
   assign rsp_lower_level    = rsp_lower_ff;
   assign rsp_count_overflow = rsp_ovf_ff;

   `ASSERT_ALWAYS(a_found_in_walk, clock, reset, found |-> cmd_in.walk_en, "median found outside walk")
   `ASSERT_ALWAYS(a_result_slot_free, clock, reset, sc_valid_ff |-> !rsp_valid_ff, "result overwrites pending result")
   `ASSERT_NEXT(a_clear_empties, clock, reset, cmd_in.clear, total_ff == '0 && !ovf_ff && bin_vld_ff == '0, "histogram not cleared")
   `ASSERT_ALWAYS(a_no_write_in_walk, clock, reset, cmd_in.walk_en |-> !s1_valid_ff, "bin write during walk")

endmodule

>>> rtl/histogram_median_thresholds.sv
// top level of the histogram median threshold block
// depends on hmt_pkg, hmt_ctrl, hmt_datapath (and through it hmt_ram)
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  gray_pixel, last_pixel
//   rsp      out        rsp_valid/rsp_ready  median, upper, lower, count_overflow
//   csr      in         csr_write_enable     csr_index, csr_write_data
//
// pixels are taken one per cycle while req_ready is high; the bin ram update is a
// two stage read-modify-write; after a last pixel the fsm flushes, then the walk reads
// one bin per cycle; the median bin goes through a scaling register, then the result
// register; a last pixel is held off while the previous result is still pending
// bins carry valid flops, so reset and the clear after the median need no ram pass
module histogram_median_thresholds (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [hmt_pkg::LEVEL_W-1:0]        req_gray_pixel,
   input  logic                               req_last_pixel,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [hmt_pkg::LEVEL_W-1:0]        rsp_median_level,
   output logic [hmt_pkg::LEVEL_W-1:0]        rsp_upper_level,
   output logic [hmt_pkg::LEVEL_W-1:0]        rsp_lower_level,
   output logic                               rsp_count_overflow,
   input  logic                               csr_write_enable,
   input  logic [hmt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [hmt_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   hmt_pkg::cmd_type    cmd;
   hmt_pkg::status_type status;

   hmt_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_last_pixel (req_last_pixel),
      .req_ready      (req_ready),
      .status_in      (status),
      .cmd_out        (cmd)
   );

   hmt_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd_in             (cmd),
      .status_out         (status),
      .req_gray_pixel     (req_gray_pixel),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_median_level   (rsp_median_level),
      .rsp_upper_level    (rsp_upper_level),
      .rsp_lower_level    (rsp_lower_level),
      .rsp_count_overflow (rsp_count_overflow)
   );

endmodule
